@@ rtl/uuidp_pkg.sv @@
// shared types and character constants for the uuid text parser
package uuidp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned COUNT_W = 6;

    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_OPEN  = 8'h7B;
    localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h7D;

    localparam logic [COUNT_W-1:0] DIGITS_TOTAL = 6'd32;

    localparam logic [HALF_W-1:0] TOP_BIT_FLIP = 64'h8000_0000_0000_0000;

    // decoded view of one character byte
    typedef struct packed {
        logic             is_hex;
        logic [NIB_W-1:0] nibble;
        logic             is_dash;
        logic             is_open;
        logic             is_close;
    } char_class_t;

    // one finished string
    typedef struct packed {
        logic [HALF_W-1:0] value_high;
        logic [HALF_W-1:0] value_low;
        logic              ok;
    } uuid_result_t;

endpackage

@@ rtl/uuidp_char_decode.sv @@
// classifies one character byte: hex digit value, dash and brackets
module uuidp_char_decode (
    input  logic [uuidp_pkg::CHAR_W-1:0] char_code,
    output uuidp_pkg::char_class_t       char_class
);

    logic [uuidp_pkg::CHAR_W-1:0] off_digit;
    logic [uuidp_pkg::CHAR_W-1:0] off_lower;
    logic [uuidp_pkg::CHAR_W-1:0] off_upper;

    assign off_digit = char_code - 8'h30;
    assign off_lower = char_code - 8'h61;
    assign off_upper = char_code - 8'h41;

    always_comb begin
        char_class.is_hex   = 1'b1;
        char_class.nibble   = '0;
        if (char_code >= 8'h30 && char_code <= 8'h39) begin
            char_class.nibble = off_digit[uuidp_pkg::NIB_W-1:0];
        end else if (char_code >= 8'h61 && char_code <= 8'h66) begin
            char_class.nibble = 4'd10 + off_lower[uuidp_pkg::NIB_W-1:0];
        end else if (char_code >= 8'h41 && char_code <= 8'h46) begin
            char_class.nibble = 4'd10 + off_upper[uuidp_pkg::NIB_W-1:0];
        end else begin
            char_class.is_hex = 1'b0;
        end
        char_class.is_dash  = (char_code == uuidp_pkg::CHAR_DASH);
        char_class.is_open  = (char_code == uuidp_pkg::CHAR_OPEN);
        char_class.is_close = (char_code == uuidp_pkg::CHAR_CLOSE);
    end

endmodule

@@ rtl/uuidp_accum.sv @@
// per-string parse state, digit shift registers and the end-of-string result
module uuidp_accum (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic                    last_char,
    input  uuidp_pkg::char_class_t  char_class,
    output uuidp_pkg::uuid_result_t result
);

    logic                          at_start_reg,     at_start_next;
    logic                          bracket_mode_reg, bracket_mode_next;
    logic                          failed_reg,       failed_next;
    logic [uuidp_pkg::COUNT_W-1:0] digit_count_reg,  digit_count_next;
    logic [uuidp_pkg::HALF_W-1:0]  high_acc_reg,     high_acc_next;
    logic [uuidp_pkg::HALF_W-1:0]  low_acc_reg,      low_acc_next;

    logic skip_open;
    logic bracket_now;
    logic closing;
    logic parse;
    logic fail_mid;
    logic fail_end;
    logic take_digit;
    logic [uuidp_pkg::COUNT_W-1:0] count_end;
    logic [uuidp_pkg::HALF_W-1:0]  high_end;
    logic [uuidp_pkg::HALF_W-1:0]  low_end;
    logic ok;

    always_comb begin
        skip_open   = at_start_reg && char_class.is_open;
        bracket_now = bracket_mode_reg || skip_open;
        closing     = last_char && bracket_now;
        parse       = !skip_open && !closing;
        fail_mid    = failed_reg || (closing && !char_class.is_close);

        take_digit = 1'b0;
        fail_end   = fail_mid;
        if (parse && !fail_mid && !char_class.is_dash) begin
            // 33rd digit or a non-hex byte
            if (digit_count_reg[uuidp_pkg::COUNT_W-1] || !char_class.is_hex) begin
                fail_end = 1'b1;
            end else begin
                take_digit = 1'b1;
            end
        end

        count_end = digit_count_reg;
        high_end  = high_acc_reg;
        low_end   = low_acc_reg;
        if (take_digit) begin
            count_end = digit_count_reg + 6'd1;
            // bit 4 set: first half already holds 16 digits
            if (digit_count_reg[4]) begin
                low_end  = {low_acc_reg[uuidp_pkg::HALF_W-5:0], char_class.nibble};
            end else begin
                high_end = {high_acc_reg[uuidp_pkg::HALF_W-5:0], char_class.nibble};
            end
        end

        ok = !fail_end && (count_end == uuidp_pkg::DIGITS_TOTAL);
        result.ok         = ok;
        result.value_high = ok ? (high_end ^ uuidp_pkg::TOP_BIT_FLIP) : '0;
        result.value_low  = ok ? low_end : '0;

        at_start_next     = at_start_reg;
        bracket_mode_next = bracket_mode_reg;
        failed_next       = failed_reg;
        digit_count_next  = digit_count_reg;
        high_acc_next     = high_acc_reg;
        low_acc_next      = low_acc_reg;
        if (step) begin
            if (last_char) begin
                at_start_next     = 1'b1;
                bracket_mode_next = 1'b0;
                failed_next       = 1'b0;
                digit_count_next  = '0;
                high_acc_next     = '0;
                low_acc_next      = '0;
            end else begin
                at_start_next     = 1'b0;
                bracket_mode_next = bracket_now;
                failed_next       = fail_end;
                digit_count_next  = count_end;
                high_acc_next     = high_end;
                low_acc_next      = low_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg     <= 1'b1;
            bracket_mode_reg <= 1'b0;
            failed_reg       <= 1'b0;
            digit_count_reg  <= '0;
            high_acc_reg     <= '0;
            low_acc_reg      <= '0;
        end else begin
            at_start_reg     <= at_start_next;
            bracket_mode_reg <= bracket_mode_next;
            failed_reg       <= failed_next;
            digit_count_reg  <= digit_count_next;
            high_acc_reg     <= high_acc_next;
            low_acc_reg      <= low_acc_next;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_count_reg <= uuidp_pkg::DIGITS_TOTAL)
        else $error("digit count above 32");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && last_char |=> at_start_reg && !failed_reg && digit_count_reg == '0
                              && !bracket_mode_reg)
        else $error("state not cleared after last character");

    a_bracket_only_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !last_char && !bracket_mode_reg && !at_start_reg |=> !bracket_mode_reg)
        else $error("bracket mode set after first character");

endmodule

@@ rtl/uuid_text_parser_unit.sv @@
// top level of the uuid text parser: input register, parse step, result register
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready/tlast    tdata[7:0] char_code, tlast last_char
//  m_axis    out  tvalid/tready          tdata[127:0] value_high, value_low; tuser ok
//
//  one character item per cycle unless a last character waits on a held result;
//  a last character raises m_axis_tvalid via the input register, then result register
//  aresetn is synchronous; it empties both registers and restarts string parsing
//  a held result stalls only a last character waiting behind it; other
//  characters keep flowing into the parse state
module uuid_text_parser_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // input characters
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
    input  logic         s_axis_tlast,   // last_char
    // parsed values
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [63:0] value_high, [127:64] value_low
    output logic         m_axis_tuser    // [0] ok
);

    // input register
    logic                         in_valid_reg, in_valid_next;
    logic [uuidp_pkg::CHAR_W-1:0] in_char_reg;
    logic                         in_last_reg;

    // result register
    logic                    out_valid_reg, out_valid_next;
    uuidp_pkg::uuid_result_t out_data_reg;

    uuidp_pkg::char_class_t  char_class;
    uuidp_pkg::uuid_result_t result;

    logic s_accept;
    logic advance;
    logic out_load;

    // a non-last character never needs the result register
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign out_load = advance && in_last_reg;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (out_load) begin
            out_data_reg <= result;
        end
    end

    uuidp_char_decode u_decode (
        .char_code  (in_char_reg),
        .char_class (char_class)
    );

    uuidp_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .last_char  (in_last_reg),
        .char_class (char_class),
        .result     (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.value_low, out_data_reg.value_high};
    assign m_axis_tuser  = out_data_reg.ok;

    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_data_reg.ok |-> out_data_reg.value_high == '0
                                              && out_data_reg.value_low == '0)
        else $error("failed string carries a nonzero value");

    a_last_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_last_reg && out_valid_reg && !m_axis_tready |=> in_valid_reg)
        else $error("last character dropped while result stalled");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !out_valid_reg || m_axis_tready)
        else $error("result register overwritten");

endmodule

@@ verif/tb_uuid_text_parser_unit.sv @@
// testbench for uuid_text_parser_unit: random uuid strings checked against a built-in parse predictor
`timescale 1ns / 100ps

module tb_uuid_text_parser_unit;

    localparam int HALF_DIGITS  = 16;
    localparam int ITEM_TARGET  = 950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;

    typedef logic [uuidp_pkg::CHAR_W-1:0] text_t[$];

    typedef enum {
        TEXT_GOOD,
        TEXT_EXTRA_DIGIT,
        TEXT_SHORT,
        TEXT_STRAY,
        TEXT_BAD_CLOSE,
        TEXT_NOISE
    } text_kind_t;

    // parse predictor and queue of expected uuid results
    class uuid_text_board_t;
        logic                            fresh;
        logic                            in_brackets;
        logic                            broken;
        logic [uuidp_pkg::COUNT_W-1:0]   n_digits;
        logic [uuidp_pkg::HALF_W-1:0]    upper_word;
        logic [uuidp_pkg::HALF_W-1:0]    lower_word;
        uuidp_pkg::uuid_result_t         expected_uuids[$];
        int                              errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            fresh       = 1'b1;
            in_brackets = 1'b0;
            broken      = 1'b0;
            n_digits    = '0;
            upper_word  = '0;
            lower_word  = '0;
        endfunction

        // nibble of a hex digit, 16 for anything else
        static function logic [4:0] hex_nibble(logic [uuidp_pkg::CHAR_W-1:0] c);
            if (c >= "0" && c <= "9") return 5'(c - "0");
            if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
            if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
            return 5'd16;
        endfunction

        // advances the parse state by one accepted item
        function void note_char(logic [uuidp_pkg::CHAR_W-1:0] c, logic last);
            logic                    parse;
            logic [4:0]              nib;
            uuidp_pkg::uuid_result_t res;
            parse = 1'b1;
            if (fresh && c == uuidp_pkg::CHAR_OPEN) begin
                in_brackets = 1'b1;
                parse = 1'b0;
            end
            fresh = 1'b0;
            if (last && in_brackets) begin
                parse = 1'b0;
                if (c != uuidp_pkg::CHAR_CLOSE) broken = 1'b1;
            end
            if (parse && !broken && c != uuidp_pkg::CHAR_DASH) begin
                nib = hex_nibble(c);
                if (n_digits >= uuidp_pkg::DIGITS_TOTAL || nib > 5'd15) begin
                    broken = 1'b1;
                end else begin
                    if (n_digits >= HALF_DIGITS)
                        lower_word = {lower_word[uuidp_pkg::HALF_W-5:0], nib[3:0]};
                    else
                        upper_word = {upper_word[uuidp_pkg::HALF_W-5:0], nib[3:0]};
                    n_digits++;
                end
            end
            if (last) begin
                res.ok         = !broken && n_digits == uuidp_pkg::DIGITS_TOTAL;
                res.value_high = res.ok ? (upper_word ^ uuidp_pkg::TOP_BIT_FLIP) : '0;
                res.value_low  = res.ok ? lower_word : '0;
                expected_uuids.push_back(res);
                restart();
            end
        endfunction

        function void check_result(logic [127:0] data, logic ok);
            uuidp_pkg::uuid_result_t want;
            if (expected_uuids.size() == 0) begin
                $error("result with none expected: tdata=%h tuser=%b", data, ok);
                errors++;
                return;
            end
            want = expected_uuids.pop_front();
            if (data[63:0] !== want.value_high) begin
                $error("value_high: expected %h, got %h", want.value_high, data[63:0]);
                errors++;
            end
            if (data[127:64] !== want.value_low) begin
                $error("value_low: expected %h, got %h", want.value_low, data[127:64]);
                errors++;
            end
            if (ok !== want.ok) begin
                $error("ok: expected %b, got %b", want.ok, ok);
                errors++;
            end
        endfunction

        function int pending();
            return expected_uuids.size();
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;   // [7:0] char_code
    logic         s_axis_tlast = 1'b0; // last_char
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // [63:0] value_high, [127:64] value_low
    logic         m_axis_tuser;        // [0] ok

    uuid_text_board_t board = new();
    int  live_items = 0;
    int  cycles = 0;
    bit  steady = 1'b0;  // no idling on either side while set

    uuid_text_parser_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random back-pressure, checked at the rising edge
    always @(negedge aclk) begin
        if (aresetn)
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    // one character item; entered and left at a falling edge
    task automatic send_char(input logic [7:0] c, input logic last);
        while (!steady && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_char(c, last);
        live_items++;
        @(negedge aclk);
    endtask

    task automatic send_text(input text_t text);
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic send_literal(input string s);
        text_t text;
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_text(text);
    endtask

    // hold the sender until every expected result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge aclk);
    endtask

    // uuid text with n digits, random case and dash layout, optional braces
    task automatic make_uuid_text(output text_t text, input int n, input bit braces);
        int         fill;
        int         dash_style;
        logic [3:0] nib;
        text = {};
        fill = $urandom_range(0, 9);
        dash_style = $urandom_range(0, 2);
        if (braces) text.push_back(uuidp_pkg::CHAR_OPEN);
        for (int i = 0; i < n; i++) begin
            // canonical layout puts dashes before digits 8, 12, 16 and 20
            if (dash_style == 0 && (i == 8 || i == 12 || i == 16 || i == 20))
                text.push_back(uuidp_pkg::CHAR_DASH);
            else if (dash_style == 2 && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2)) text.push_back(uuidp_pkg::CHAR_DASH);
            nib = (fill == 0) ? 4'h0 : (fill == 1) ? 4'hF : 4'($urandom_range(0, 15));
            if (nib < 10)
                text.push_back(8'("0" + nib));
            else if ($urandom_range(0, 1))
                text.push_back(8'("a" + nib - 10));
            else
                text.push_back(8'("A" + nib - 10));
        end
        if (dash_style == 2 && $urandom_range(0, 4) == 0)
            text.push_back(uuidp_pkg::CHAR_DASH);
        if (braces) text.push_back(uuidp_pkg::CHAR_CLOSE);
        if (text.size() == 0) text.push_back(uuidp_pkg::CHAR_DASH);
    endtask

    initial begin
        text_t      text;
        text_kind_t kind;
        int         pick;
        int         n_strings;
        logic [7:0] c;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // short directed strings: lone and misplaced braces, hex range edges
        send_literal("{");
        send_literal("}");
        send_literal("-");
        send_literal("{-}");
        send_literal("{0");
        send_literal("/09:");
        send_literal("@AFG");
        send_literal("`afg");
        send_literal("a{b}");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        drain_results();

        n_strings = 0;
        while (live_items < ITEM_TARGET) begin
            steady = (n_strings >= 10 && n_strings < 18);
            pick = $urandom_range(0, 99);
            kind = (pick < 65) ? TEXT_GOOD :
                   (pick < 73) ? TEXT_EXTRA_DIGIT :
                   (pick < 81) ? TEXT_SHORT :
                   (pick < 89) ? TEXT_STRAY :
                   (pick < 94) ? TEXT_BAD_CLOSE : TEXT_NOISE;
            case (kind)
                TEXT_GOOD: begin
                    make_uuid_text(text, uuidp_pkg::DIGITS_TOTAL, 1'($urandom_range(0, 1)));
                end
                TEXT_EXTRA_DIGIT: begin
                    make_uuid_text(text, $urandom_range(33, 34), 1'($urandom_range(0, 1)));
                end
                TEXT_SHORT: begin
                    make_uuid_text(text, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
                end
                TEXT_STRAY: begin
                    // a byte that is neither hex nor dash, somewhere after the start
                    do c = 8'($urandom_range(0, 255));
                    while (uuid_text_board_t::hex_nibble(c) != 5'd16
                           || c == uuidp_pkg::CHAR_DASH);
                    if ($urandom_range(0, 1)) begin
                        make_uuid_text(text, uuidp_pkg::DIGITS_TOTAL, 1'b1);
                        text.insert($urandom_range(1, text.size() - 1), c);
                    end else begin
                        make_uuid_text(text, uuidp_pkg::DIGITS_TOTAL, 1'b0);
                        text.insert($urandom_range(1, text.size()), c);
                    end
                end
                TEXT_BAD_CLOSE: begin
                    make_uuid_text(text, uuidp_pkg::DIGITS_TOTAL, 1'b1);
                    do c = 8'($urandom_range(0, 255)); while (c == uuidp_pkg::CHAR_CLOSE);
                    text[text.size() - 1] = c;
                end
                default: begin
                    text = {};
                    repeat ($urandom_range(1, 40)) text.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            send_text(text);
            n_strings++;
            if ($urandom_range(0, 19) == 0) drain_results();
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
